### design/tsfr_pkg.sv
package tsfr_pkg;

  // Packet framing
  localparam int unsigned PKT_LEN    = 188;
  localparam int unsigned POS_W      = 8;
  localparam logic [12:0] NULL_PID   = 13'h1FFF;

  // Counter wrap: count*2 reaching the limit means count >= limit/2 (rounded up)
  localparam int unsigned WRAP_LIMIT = 454263790;
  localparam int unsigned WRAP_COUNT = (WRAP_LIMIT + 1) / 2;
  localparam int unsigned COUNT_W    = 28;

  // Stamp arithmetic
  localparam int unsigned BYTES_PER_PKT_BITS = 1504;
  localparam int unsigned SCALE_W    = 11;
  localparam int unsigned STAMP_W    = 30;
  localparam int unsigned RATE_W     = 30;
  localparam int unsigned CLK_W      = 26;
  localparam int unsigned CLK_HALF_W = CLK_W / 2;
  localparam int unsigned A_W        = COUNT_W + SCALE_W;     // count*1504
  localparam int unsigned PROD_W     = A_W + CLK_HALF_W;      // one partial product
  localparam int unsigned NUM_W      = A_W + CLK_W;           // full dividend
  localparam int unsigned DCNT_W     = $clog2(NUM_W);

  // Header: four stamp bytes then three held packet bytes
  localparam int unsigned HDR_BEATS  = 7;
  localparam int unsigned HIDX_W     = $clog2(HDR_BEATS);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 30;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COPY_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ  = 2'd2;

  localparam logic [RATE_W-1:0] RST_BIT_RATE = 30'd48000000;
  localparam logic [CLK_W-1:0]  RST_CLOCK_HZ = 26'd27000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULH,
    ST_MULL,
    ST_DIV,
    ST_SUM,
    ST_HDR
  } tsfr_state_t;

endpackage

### design/ts_to_m2ts_timestamp_framer_core.sv
// Transport stream to M2TS framer. Takes 188-byte TS packets one byte per beat and
// emits 192-byte packets: a 4-byte header (copy bits, 30-bit arrival stamp) then the
// packet bytes, with out_packet_end on the last byte. Null packets (PID 0x1FFF) are
// dropped but still counted. Bytes 0 and 1 of a packet and bytes 3..187 are taken
// whenever the output register is free. On byte 2 of a kept packet the core stops taking
// input: after the accepting cycle it runs a shared 39x13 multiplier over the high then
// low clock half, a one-bit-per-cycle restoring divider, an add of the carry, then seven
// header beats, plus any output stalls. Byte 2 of a null packet is taken like the others.
// Configuration may only be written while no packet bytes are in flight.
module ts_to_m2ts_timestamp_framer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tsfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tsfr_pkg::CFG_DATA_W-1:0]   cfg_data,
  // transport stream in
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_ts_byte,
  // framed stream out
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_byte,
  output logic                              out_packet_end
);
  import tsfr_pkg::*;

  tsfr_state_t state_r, state_nxt;

  // configuration
  logic [RATE_W-1:0]  bit_rate_r;
  logic [1:0]         copy_bits_r;
  logic [CLK_W-1:0]   clock_hz_r;

  // packet tracking
  logic [POS_W-1:0]   pos_r;
  logic [7:0]         held0_r, held1_r, held2_r;
  logic               drop_r;
  logic [COUNT_W-1:0] count_r;
  logic [STAMP_W-1:0] carry_r;
  logic [STAMP_W-1:0] last_stamp_r;
  logic [STAMP_W-1:0] stamp_r;

  // arithmetic unit
  logic [A_W-1:0]     a_r;
  logic [NUM_W-1:0]   num_r;
  logic [STAMP_W-1:0] rem_r;
  logic [STAMP_W-1:0] quo_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [HIDX_W-1:0]  hidx_r;

  // output register
  logic               out_valid_r;
  logic [7:0]         out_byte_r;
  logic               out_end_r;

  logic               out_free;
  logic               in_fire;
  logic               hdr_load;
  logic [12:0]        pid;
  logic               is_null;
  logic [RATE_W-1:0]  div_w;
  logic [CLK_HALF_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [RATE_W:0]    rem_sh;
  logic               rem_ge;
  logic [STAMP_W-1:0] stamp_sum;
  logic               wrap;
  logic [7:0]         hdr_byte;
  logic               last_pos;

  assign out_free = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign pid      = {held1_r[4:0], in_ts_byte};
  assign is_null  = (pid == NULL_PID);
  assign last_pos = (pos_r == POS_W'(PKT_LEN - 1));
  assign wrap     = (count_r >= COUNT_W'(WRAP_COUNT));

  // shared multiplier: high clock half first, then low half
  assign mul_b = (state_r == ST_MULH) ? clock_hz_r[CLK_W-1:CLK_HALF_W]
                                      : clock_hz_r[CLK_HALF_W-1:0];
  assign mul_p = PROD_W'(a_r) * PROD_W'(mul_b);

  // divider step; zero rate divides by one
  assign div_w  = (bit_rate_r == '0) ? RATE_W'(1) : bit_rate_r;
  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, div_w});

  assign stamp_sum = quo_r + carry_r;

  // header beat select
  always_comb begin
    case (hidx_r)
      3'd0:    hdr_byte = {copy_bits_r, stamp_r[29:24]};
      3'd1:    hdr_byte = stamp_r[23:16];
      3'd2:    hdr_byte = stamp_r[15:8];
      3'd3:    hdr_byte = stamp_r[7:0];
      3'd4:    hdr_byte = held0_r;
      3'd5:    hdr_byte = held1_r;
      default: hdr_byte = held2_r;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && pos_r == POS_W'(2) && !is_null) state_nxt = ST_MULH;
      end
      ST_MULH: state_nxt = ST_MULL;
      ST_MULL: state_nxt = ST_DIV;
      ST_DIV: begin
        if (dcnt_r == '0) state_nxt = ST_SUM;
      end
      ST_SUM:  state_nxt = ST_HDR;
      ST_HDR: begin
        if (out_free && hidx_r == HIDX_W'(HDR_BEATS - 1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    hdr_load = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = out_free;
      ST_HDR:  hdr_load = out_free;
      default: begin
        in_ready = 1'b0;
        hdr_load = 1'b0;
      end
    endcase
  end

  assign cfg_ready = 1'b1;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      bit_rate_r   <= RST_BIT_RATE;
      copy_bits_r  <= 2'd0;
      clock_hz_r   <= RST_CLOCK_HZ;
      pos_r        <= '0;
      drop_r       <= 1'b0;
      count_r      <= '0;
      carry_r      <= '0;
      last_stamp_r <= '0;
      hidx_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BIT_RATE:  bit_rate_r  <= cfg_data[RATE_W-1:0];
          CFG_COPY_BITS: copy_bits_r <= cfg_data[1:0];
          CFG_CLOCK_HZ:  clock_hz_r  <= cfg_data[CLK_W-1:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        pos_r <= last_pos ? '0 : pos_r + POS_W'(1);
        if (pos_r == POS_W'(2)) begin
          drop_r <= is_null;
          // null packet: count now; kept packet counts once its stamp is known
          if (is_null) begin
            count_r <= wrap ? COUNT_W'(1) : count_r + COUNT_W'(1);
            if (wrap) carry_r <= last_stamp_r;
          end
        end
      end

      if (state_r == ST_SUM) begin
        last_stamp_r <= stamp_sum;
        count_r      <= wrap ? COUNT_W'(1) : count_r + COUNT_W'(1);
        if (wrap) carry_r <= stamp_sum;
      end

      if (state_r == ST_SUM) hidx_r <= '0;
      else if (hdr_load)     hidx_r <= hidx_r + HIDX_W'(1);

      if (hdr_load || (in_fire && pos_r > POS_W'(2) && !drop_r))
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (pos_r == POS_W'(0)) held0_r <= in_ts_byte;
      if (pos_r == POS_W'(1)) held1_r <= in_ts_byte;
      if (pos_r == POS_W'(2)) begin
        held2_r <= in_ts_byte;
        a_r     <= A_W'(count_r) * A_W'(BYTES_PER_PKT_BITS);
      end
    end

    case (state_r)
      ST_MULH: num_r <= NUM_W'(mul_p);
      ST_MULL: begin
        num_r  <= (num_r << CLK_HALF_W) + NUM_W'(mul_p);
        rem_r  <= '0;
        quo_r  <= '0;
        dcnt_r <= DCNT_W'(NUM_W - 1);
      end
      ST_DIV: begin
        num_r  <= num_r << 1;
        rem_r  <= rem_ge ? STAMP_W'(rem_sh - {1'b0, div_w}) : rem_sh[STAMP_W-1:0];
        quo_r  <= {quo_r[STAMP_W-2:0], rem_ge};
        dcnt_r <= dcnt_r - DCNT_W'(1);
      end
      ST_SUM:  stamp_r <= stamp_sum;
      default: ;
    endcase

    if (hdr_load) begin
      out_byte_r <= hdr_byte;
      out_end_r  <= 1'b0;
    end else if (in_fire && pos_r > POS_W'(2) && !drop_r) begin
      out_byte_r <= in_ts_byte;
      out_end_r  <= last_pos;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_packet_end = out_end_r;

  // checks
  a_busy_no_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("input taken while stamp unit busy");

  a_hdr_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HDR) |-> (hidx_r < HIDX_W'(HDR_BEATS)))
    else $error("header beat index out of range");

  a_end_wraps_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_packet_end) |-> (pos_r == '0))
    else $error("packet end shown without position wrap");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < div_w))
    else $error("divider remainder not below divisor");

endmodule
